@@ hw/rtl/hxdg_pkg.sv @@
package hxdg_pkg;

  // Clamp limit for array extents and element size in bytes
  localparam int unsigned MAX_DIM         = 1024;
  localparam int unsigned BYTES_PER_VALUE = 4;

  // Field widths
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned BYTES_W = 23;
  localparam int unsigned ROWS_W  = 21;
  localparam int unsigned PROD_W  = 2 * DIM_W;
  localparam int unsigned SCL_W   = PROD_W + 4;

  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
  localparam logic [ROWS_W-1:0]  ROWS_MAX  = '1;

  // Direction component codes (2-bit two's complement)
  localparam logic [DIR_W-1:0] DIR_ZERO = 2'b00;
  localparam logic [DIR_W-1:0] DIR_POS  = 2'b01;
  localparam logic [DIR_W-1:0] DIR_BAD  = 2'b10;
  localparam logic [DIR_W-1:0] DIR_NEG  = 2'b11;

  // Copy shape of one direction
  typedef enum logic [2:0] {
    SH_ZERO,
    SH_FACE_X,
    SH_FACE_Y,
    SH_FACE_Z,
    SH_EDGE_X,
    SH_EDGE_Y,
    SH_EDGE_Z,
    SH_CORNER
  } shape_t;

  // Force an extent into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Scale an element count to bytes and saturate
  function automatic logic [BYTES_W-1:0] to_bytes(input logic [PROD_W-1:0] v);
    logic [SCL_W-1:0] s;
    logic [BYTES_W-1:0] r;
    s = SCL_W'(v) * SCL_W'(BYTES_PER_VALUE);
    if (s > SCL_W'(BYTES_MAX)) begin
      r = BYTES_MAX;
    end else begin
      r = s[BYTES_W-1:0];
    end
    return r;
  endfunction

  // Saturate a row count
  function automatic logic [ROWS_W-1:0] sat_rows(input logic [PROD_W-1:0] v);
    logic [ROWS_W-1:0] r;
    if (v > PROD_W'(ROWS_MAX)) begin
      r = ROWS_MAX;
    end else begin
      r = v[ROWS_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/halo_exchange_descriptor_gen.sv @@
// Halo exchange descriptor generator.
// Input: one beat carries a neighbor direction (three components, each -1..1
// in 2-bit two's complement) and the source and destination extents. A beat
// is taken at each rising edge where start is high and busy is low; busy is
// always low, so a new beat may enter every cycle.
// Output: one descriptor per input beat (start coordinates, byte pitches,
// row length in bytes, row count), shown for exactly one cycle with
// out_valid high. Results leave in input order.
// Each accepted beat passes through three register stages (decode and clamp,
// extent products, shape select with byte scaling) to out_valid. Throughput:
// one beat per cycle, with no shared unit.
// A zero or malformed direction gives an all-zero descriptor.
// Reset (synchronous, active low) clears the stage valid bits, so nothing in
// flight is delivered. The receiver cannot stall: out_valid is a strobe and
// the pipeline never holds.
module halo_exchange_descriptor_gen (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [hxdg_pkg::DIR_W-1:0]     in_dir_x,
  input  logic [hxdg_pkg::DIR_W-1:0]     in_dir_y,
  input  logic [hxdg_pkg::DIR_W-1:0]     in_dir_z,
  input  logic [hxdg_pkg::DIM_W-1:0]     in_src_dim_x,
  input  logic [hxdg_pkg::DIM_W-1:0]     in_src_dim_y,
  input  logic [hxdg_pkg::DIM_W-1:0]     in_src_dim_z,
  input  logic [hxdg_pkg::DIM_W-1:0]     in_dst_dim_x,
  input  logic [hxdg_pkg::DIM_W-1:0]     in_dst_dim_y,
  input  logic [hxdg_pkg::DIM_W-1:0]     in_dst_dim_z,
  output logic                           out_valid,
  output logic [hxdg_pkg::COORD_W-1:0]   out_src_x,
  output logic [hxdg_pkg::COORD_W-1:0]   out_src_y,
  output logic [hxdg_pkg::COORD_W-1:0]   out_src_z,
  output logic [hxdg_pkg::COORD_W-1:0]   out_dst_x,
  output logic [hxdg_pkg::COORD_W-1:0]   out_dst_y,
  output logic [hxdg_pkg::COORD_W-1:0]   out_dst_z,
  output logic [hxdg_pkg::BYTES_W-1:0]   out_src_stride_bytes,
  output logic [hxdg_pkg::BYTES_W-1:0]   out_dst_stride_bytes,
  output logic [hxdg_pkg::BYTES_W-1:0]   out_row_bytes,
  output logic [hxdg_pkg::ROWS_W-1:0]    out_row_count
);
  import hxdg_pkg::*;

  logic in_fire;

  // Stage 1 registers
  logic               s1_valid_r;
  shape_t             s1_shape_r;
  logic [DIR_W-1:0]   s1_dir_r [3];
  logic [DIM_W-1:0]   s1_a_r   [3];
  logic [DIM_W-1:0]   s1_b_r   [3];

  // Stage 2 registers
  logic               s2_valid_r;
  shape_t             s2_shape_r;
  logic [COORD_W-1:0] s2_src_r [3];
  logic [COORD_W-1:0] s2_dst_r [3];
  logic [DIM_W-1:0]   s2_a_r   [3];
  logic [DIM_W-1:0]   s2_b0_r;
  logic [PROD_W-1:0]  s2_pa_r;
  logic [PROD_W-1:0]  s2_pb_r;
  logic [PROD_W-1:0]  s2_ph_r;

  // Stage 3 (output) registers
  logic               s3_valid_r;
  logic [COORD_W-1:0] s3_src_r [3];
  logic [COORD_W-1:0] s3_dst_r [3];
  logic [BYTES_W-1:0] s3_ss_r;
  logic [BYTES_W-1:0] s3_ds_r;
  logic [BYTES_W-1:0] s3_w_r;
  logic [ROWS_W-1:0]  s3_h_r;

  // Next values
  shape_t             shape_nxt;
  logic [COORD_W-1:0] src_nxt [3];
  logic [COORD_W-1:0] dst_nxt [3];
  logic [PROD_W-1:0]  ss_nxt;
  logic [PROD_W-1:0]  ds_nxt;
  logic [PROD_W-1:0]  w_nxt;
  logic [PROD_W-1:0]  h_nxt;

  // Never hold off the sender
  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // Stage 1: classify direction into a shape
  always_comb begin
    logic ok;
    logic nzx, nzy, nzz;
    ok  = (in_dir_x != DIR_BAD) && (in_dir_y != DIR_BAD) && (in_dir_z != DIR_BAD);
    nzx = (in_dir_x != DIR_ZERO);
    nzy = (in_dir_y != DIR_ZERO);
    nzz = (in_dir_z != DIR_ZERO);
    priority if (!ok || (!nzx && !nzy && !nzz)) begin
      shape_nxt = SH_ZERO;
    end else if (nzx && nzy && nzz) begin
      shape_nxt = SH_CORNER;
    end else if (nzx && !nzy && !nzz) begin
      shape_nxt = SH_FACE_X;
    end else if (!nzx && nzy && !nzz) begin
      shape_nxt = SH_FACE_Y;
    end else if (!nzx && !nzy && nzz) begin
      shape_nxt = SH_FACE_Z;
    end else if (!nzz) begin
      shape_nxt = SH_EDGE_Z;
    end else if (!nzy) begin
      shape_nxt = SH_EDGE_Y;
    end else begin
      shape_nxt = SH_EDGE_X;
    end
  end

  // Stage 2: start coordinates per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      src_nxt[i] = '0;
      dst_nxt[i] = '0;
      if (s1_shape_r != SH_ZERO) begin
        if (s1_dir_r[i] == DIR_POS) begin
          src_nxt[i] = COORD_W'(s1_a_r[i] - DIM_W'(2));
        end else if (s1_dir_r[i] == DIR_NEG) begin
          src_nxt[i] = COORD_W'(1);
          dst_nxt[i] = COORD_W'(s1_b_r[i] - DIM_W'(1));
        end
      end
    end
  end

  // Stage 3: pick pitches and lengths for the shape
  always_comb begin
    ss_nxt = '0;
    ds_nxt = '0;
    w_nxt  = '0;
    h_nxt  = '0;
    unique case (s2_shape_r)
      SH_ZERO: begin
        ss_nxt = '0;
      end
      SH_FACE_X: begin
        ss_nxt = PROD_W'(s2_a_r[0]);
        ds_nxt = PROD_W'(s2_b0_r);
        w_nxt  = PROD_W'(1);
        h_nxt  = s2_ph_r;
      end
      SH_FACE_Y: begin
        ss_nxt = s2_pa_r;
        ds_nxt = s2_pb_r;
        w_nxt  = PROD_W'(s2_a_r[0]);
        h_nxt  = PROD_W'(s2_a_r[2]);
      end
      SH_FACE_Z: begin
        ss_nxt = s2_pa_r;
        ds_nxt = s2_pb_r;
        w_nxt  = s2_pa_r;
        h_nxt  = PROD_W'(1);
      end
      SH_EDGE_Z: begin
        ss_nxt = s2_pa_r;
        ds_nxt = s2_pb_r;
        w_nxt  = PROD_W'(1);
        h_nxt  = PROD_W'(s2_a_r[2]);
      end
      SH_EDGE_Y: begin
        ss_nxt = PROD_W'(s2_a_r[0]);
        ds_nxt = PROD_W'(s2_b0_r);
        w_nxt  = PROD_W'(1);
        h_nxt  = PROD_W'(s2_a_r[1]);
      end
      SH_EDGE_X: begin
        ss_nxt = PROD_W'(s2_a_r[0]);
        ds_nxt = PROD_W'(s2_b0_r);
        w_nxt  = PROD_W'(s2_a_r[0]);
        h_nxt  = PROD_W'(1);
      end
      SH_CORNER: begin
        ss_nxt = PROD_W'(1);
        ds_nxt = PROD_W'(1);
        w_nxt  = PROD_W'(1);
        h_nxt  = PROD_W'(1);
      end
      default: begin
        ss_nxt = '0;
      end
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Stage 1 payload: decode and clamp extents
  always_ff @(posedge clk) begin
    s1_shape_r  <= shape_nxt;
    s1_dir_r[0] <= in_dir_x;
    s1_dir_r[1] <= in_dir_y;
    s1_dir_r[2] <= in_dir_z;
    s1_a_r[0]   <= clamp_dim(in_src_dim_x);
    s1_a_r[1]   <= clamp_dim(in_src_dim_y);
    s1_a_r[2]   <= clamp_dim(in_src_dim_z);
    s1_b_r[0]   <= clamp_dim(in_dst_dim_x);
    s1_b_r[1]   <= clamp_dim(in_dst_dim_y);
    s1_b_r[2]   <= clamp_dim(in_dst_dim_z);
  end

  // Stage 2 payload: coordinates and extent products
  always_ff @(posedge clk) begin
    s2_shape_r <= s1_shape_r;
    s2_src_r   <= src_nxt;
    s2_dst_r   <= dst_nxt;
    s2_a_r     <= s1_a_r;
    s2_b0_r    <= s1_b_r[0];
    s2_pa_r    <= PROD_W'(s1_a_r[0]) * PROD_W'(s1_a_r[1]);
    s2_pb_r    <= PROD_W'(s1_b_r[0]) * PROD_W'(s1_b_r[1]);
    s2_ph_r    <= PROD_W'(s1_a_r[1]) * PROD_W'(s1_a_r[2]);
  end

  // Stage 3 payload: scale to bytes and saturate
  always_ff @(posedge clk) begin
    s3_src_r <= s2_src_r;
    s3_dst_r <= s2_dst_r;
    s3_ss_r  <= to_bytes(ss_nxt);
    s3_ds_r  <= to_bytes(ds_nxt);
    s3_w_r   <= to_bytes(w_nxt);
    s3_h_r   <= sat_rows(h_nxt);
  end

  assign out_valid            = s3_valid_r;
  assign out_src_x            = s3_src_r[0];
  assign out_src_y            = s3_src_r[1];
  assign out_src_z            = s3_src_r[2];
  assign out_dst_x            = s3_dst_r[0];
  assign out_dst_y            = s3_dst_r[1];
  assign out_dst_z            = s3_dst_r[2];
  assign out_src_stride_bytes = s3_ss_r;
  assign out_dst_stride_bytes = s3_ds_r;
  assign out_row_bytes        = s3_w_r;
  assign out_row_count        = s3_h_r;

  // Every accepted beat yields a result on out_valid
  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##3 out_valid)
    else $error("accepted beat produced no result");

  // No result without a matching accepted beat
  a_out_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(in_fire, 3) && $past(rst_n, 3)))
    else $error("result without matching input beat");

  // A zero row count only comes from the all-zero descriptor
  a_zero_desc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_row_count == '0)) |->
      ((out_src_x == '0) && (out_dst_x == '0) && (out_row_bytes == '0) &&
       (out_src_stride_bytes == '0) && (out_dst_stride_bytes == '0)))
    else $error("zero row count with nonzero descriptor fields");

  // A real copy moves at least one element per row
  a_row_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_row_count != '0)) |->
      ((out_row_bytes >= BYTES_W'(BYTES_PER_VALUE)) &&
       (out_src_stride_bytes >= BYTES_W'(BYTES_PER_VALUE))))
    else $error("copy descriptor with empty row or pitch");

endmodule
